// ===== sv/mocf_pkg.sv =====
// Shared constants, operation codes and controller/datapath interface types.
package mocf_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int KEY_W       = 48;
  localparam int OFS_W       = 16;
  localparam int KIND_W      = 2;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the incoming transaction
    logic clear;    // empty the table
    logic scan;     // one compare step
    logic write;    // insert/update write
    logic set_out;  // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage

// ===== sv/mac_offset_cache_fifo.sv =====
// Top level of the MAC-to-offset cache with FIFO replacement.
// Fully associative MAC-to-offset cache of TABLE_DEPTH entries, one transaction at a time.
// Lookups and inserts scan the valid entries in index order through one registered read
// port of the key/offset memories, comparing one entry per cycle and stopping at the first
// match. A lookup goes from accept through the scan to the result register; an insert
// adds a memory write step after its scan. A clear, or an unused kind, goes straight from
// accept to the result register. A new transaction is accepted while the previous result
// still waits on the output. No clearing pass after reset.
module mac_offset_cache_fifo #(
  parameter int TABLE_DEPTH = mocf_pkg::TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [47:0] mac_key, [63:48] offset_in
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] offset_out
  output logic        out_tuser   // [0] hit
);

  mocf_pkg::cmd_t cmd;
  mocf_pkg::sts_t sts;

  mocf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  mocf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_kind (in_tuser),
    .in_key  (in_tdata[47:0]),
    .in_ofs  (in_tdata[63:48]),
    .out_hit (out_tuser),
    .out_ofs (out_tdata)
  );

endmodule

// ===== sv/mocf_dp.sv =====
// Datapath: key/offset memories, fill count, replace pointer, scan and result registers.
module mocf_dp #(
  parameter int TABLE_DEPTH = mocf_pkg::TABLE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mocf_pkg::cmd_t              cmd,
  output mocf_pkg::sts_t              sts,
  input  logic [mocf_pkg::KIND_W-1:0] in_kind,
  input  logic [mocf_pkg::KEY_W-1:0]  in_key,
  input  logic [mocf_pkg::OFS_W-1:0]  in_ofs,
  output logic                        out_hit,
  output logic [mocf_pkg::OFS_W-1:0]  out_ofs
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(TABLE_DEPTH - 1);

  logic [mocf_pkg::KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [mocf_pkg::OFS_W-1:0] val_mem [TABLE_DEPTH];

  logic [mocf_pkg::KIND_W-1:0] kind_r;
  logic [mocf_pkg::KEY_W-1:0]  key_r;
  logic [mocf_pkg::OFS_W-1:0]  ofs_r;
  logic [CNT_W-1:0]            fill_r, fill_nxt;
  logic [IDX_W-1:0]            ptr_r, ptr_nxt;
  logic [CNT_W-1:0]            rd_idx_r;
  logic                        cmp_vld_r;
  logic [IDX_W-1:0]            cmp_idx_r;
  logic [mocf_pkg::KEY_W-1:0]  key_q_r;
  logic [mocf_pkg::OFS_W-1:0]  val_q_r;
  logic                        hit_r;
  logic [IDX_W-1:0]            hit_idx_r;
  logic [mocf_pkg::OFS_W-1:0]  res_ofs_r;
  logic                        out_hit_r;
  logic [mocf_pkg::OFS_W-1:0]  out_ofs_r;

  logic                        rd_more;
  logic                        match;
  logic                        wr_en;
  logic                        wr_key;
  logic [IDX_W-1:0]            wr_addr;

  assign rd_more = (rd_idx_r < fill_r);
  assign match   = cmd.scan && cmp_vld_r && (key_q_r == key_r);
  // the entry in the compare stage is checked this cycle, so nothing is left once reads run out
  assign sts.scan_done = match || !rd_more;

  // clear resets fill and pointer; insert/update: hit rewrites the offset, miss appends or overwrites in FIFO order
  always_comb begin
    fill_nxt = fill_r;
    ptr_nxt  = ptr_r;
    wr_en    = 1'b0;
    wr_key   = 1'b0;
    wr_addr  = ptr_r;
    if (cmd.clear) begin
      fill_nxt = '0;
      ptr_nxt  = '0;
    end else if (cmd.write) begin
      wr_en = 1'b1;
      if (hit_r) begin
        wr_addr = hit_idx_r;
      end else if (fill_r < DEPTH_C) begin
        wr_key   = 1'b1;
        wr_addr  = fill_r[IDX_W-1:0];
        fill_nxt = fill_r + CNT_W'(1);
      end else begin
        wr_key  = 1'b1;
        wr_addr = ptr_r;
        ptr_nxt = (ptr_r == LAST_C) ? '0 : ptr_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      ptr_r     <= '0;
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      ptr_r  <= ptr_nxt;
      if (cmd.load) begin
        rd_idx_r  <= '0;
        cmp_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        rd_idx_r  <= rd_more ? rd_idx_r + CNT_W'(1) : rd_idx_r;
        cmp_vld_r <= rd_more;
      end
    end
  end

  // memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_mem[wr_addr] <= ofs_r;
      if (wr_key) begin
        key_mem[wr_addr] <= key_r;
      end
    end
    if (cmd.scan) begin
      key_q_r   <= key_mem[rd_idx_r[IDX_W-1:0]];
      val_q_r   <= val_mem[rd_idx_r[IDX_W-1:0]];
      cmp_idx_r <= rd_idx_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      key_r     <= in_key;
      ofs_r     <= in_ofs;
      hit_r     <= 1'b0;
      res_ofs_r <= '0;
    end else if (match) begin
      hit_r     <= 1'b1;
      hit_idx_r <= cmp_idx_r;
      if (kind_r == mocf_pkg::KIND_LOOKUP) begin
        res_ofs_r <= val_q_r;
      end
    end
    if (cmd.set_out) begin
      out_hit_r <= hit_r;
      out_ofs_r <= res_ofs_r;
    end
  end

  assign out_hit = out_hit_r;
  assign out_ofs = out_ofs_r;

endmodule

// ===== sv/mocf_ctrl.sv =====
// Controller: sequences accept, scan, write and result hand-off.
module mocf_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mocf_pkg::KIND_W-1:0] in_kind,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output mocf_pkg::cmd_t              cmd,
  input  mocf_pkg::sts_t              sts
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [mocf_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic                        accept;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          kind_nxt = in_kind;
          if (in_kind == mocf_pkg::KIND_LOOKUP || in_kind == mocf_pkg::KIND_INSERT) begin
            state_nxt = S_SCAN;
          end else begin
            cmd.clear = (in_kind == mocf_pkg::KIND_CLEAR);
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = (kind_r == mocf_pkg::KIND_INSERT) ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.set_out = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.set_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      kind_r      <= mocf_pkg::KIND_LOOKUP;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
    end
  end

endmodule

// ===== test/mocf_checker.sv =====
// Scoreboard for the MAC-to-offset cache: watches both streams, predicts and compares.
`timescale 1ns / 1ps

module mocf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // [47:0] mac_key, [63:48] offset_in
  input  logic [1:0]  in_tuser,   // [1:0] kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [15:0] offset_out
  input  logic        out_tuser,  // [0] hit
  output int          fail_count,
  output int          pending,
  output int          hit_count,
  output int          evict_count
);

  typedef struct packed {
    logic                       hit;
    logic [mocf_pkg::OFS_W-1:0] ofs;
  } answer_t;

  logic [mocf_pkg::KEY_W-1:0] key_mem [mocf_pkg::TABLE_DEPTH];
  logic [mocf_pkg::OFS_W-1:0] ofs_mem [mocf_pkg::TABLE_DEPTH];
  int unsigned                fill_cnt;
  int unsigned                repl_ptr;
  answer_t                    answer_q[$];
  int                         n_fail;
  int                         n_hit;
  int                         n_evict;

  assign fail_count  = n_fail;
  assign hit_count   = n_hit;
  assign evict_count = n_evict;

  // Mirror of the table; returns the answer and applies the side effects.
  function automatic answer_t cache_access(input logic [mocf_pkg::KIND_W-1:0] kind,
                                           input logic [mocf_pkg::KEY_W-1:0]  key,
                                           input logic [mocf_pkg::OFS_W-1:0]  ofs);
    answer_t ans;
    int      idx;
    int      i;
    ans = '0;
    idx = -1;
    // only valid entries take part; lowest index wins
    for (i = 0; i < int'(fill_cnt); i++) begin
      if (idx < 0 && key_mem[i] == key) idx = i;
    end
    case (kind)
      mocf_pkg::KIND_LOOKUP: begin
        if (idx >= 0) begin
          ans.hit = 1'b1;
          ans.ofs = ofs_mem[idx];
        end
      end
      mocf_pkg::KIND_INSERT: begin
        if (idx >= 0) begin
          ans.hit      = 1'b1;
          ofs_mem[idx] = ofs;
        end else if (fill_cnt < mocf_pkg::TABLE_DEPTH) begin
          key_mem[fill_cnt] = key;
          ofs_mem[fill_cnt] = ofs;
          fill_cnt++;
        end else begin
          key_mem[repl_ptr] = key;
          ofs_mem[repl_ptr] = ofs;
          repl_ptr = (repl_ptr + 1) % mocf_pkg::TABLE_DEPTH;
          n_evict++;
        end
      end
      mocf_pkg::KIND_CLEAR: begin
        fill_cnt = 0;
        repl_ptr = 0;
      end
      default: ;
    endcase
    return ans;
  endfunction

  initial begin
    n_fail  = 0;
    n_hit   = 0;
    n_evict = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    answer_t exp_ans;
    if (!rst_n) begin
      answer_q.delete();
      fill_cnt = 0;
      repl_ptr = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result transaction hit=%0b offset=%h",
                   $time, out_tuser, out_tdata);
          n_fail++;
        end else begin
          exp_ans = answer_q.pop_front();
          if (out_tuser !== exp_ans.hit) begin
            $display("%0t: hit mismatch, expected %0b actual %0b",
                     $time, exp_ans.hit, out_tuser);
            n_fail++;
          end
          if (out_tdata !== exp_ans.ofs) begin
            $display("%0t: offset mismatch, expected %h actual %h",
                     $time, exp_ans.ofs, out_tdata);
            n_fail++;
          end
          if (exp_ans.hit) n_hit++;
        end
      end
      if (in_tvalid && in_tready)
        answer_q.insert(answer_q.size(),
                        cache_access(in_tuser, in_tdata[mocf_pkg::KEY_W-1:0],
                                     in_tdata[63:mocf_pkg::KEY_W]));
    end
    pending = answer_q.size();
  end

endmodule

// ===== test/mac_offset_cache_fifo_tb.sv =====
// Testbench top for the MAC-to-offset cache: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module mac_offset_cache_fifo_tb;

  localparam logic [mocf_pkg::KIND_W-1:0] KIND_RESERVED = 2'd3;
  localparam int POOL_SIZE   = 48;
  localparam int SEGMENTS    = 5;
  localparam int SEG_ITEMS   = 150;
  localparam int FILL_ITEMS  = 40;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;

  int fail_count;
  int pending;
  int hit_count;
  int evict_count;

  logic [mocf_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  bit                         tx_calm;
  bit                         rx_calm;
  int                         cycle_cnt;
  int                         n_sent;
  int                         n_clear;

  mac_offset_cache_fifo dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  mocf_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .hit_count  (hit_count),
    .evict_count(evict_count)
  );

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    cycle_cnt  = 0;
    n_sent     = 0;
    n_clear    = 0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stall before each transaction, none while rx_calm.
  initial begin
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 6);
      if (stall == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
        out_tready <= 1'b1;
      end
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(input logic [mocf_pkg::KIND_W-1:0] kind,
                         input logic [mocf_pkg::KEY_W-1:0] key,
                         input logic [mocf_pkg::OFS_W-1:0] ofs);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {ofs, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    n_sent++;
    if (kind == mocf_pkg::KIND_CLEAR) n_clear++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [mocf_pkg::KEY_W-1:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[mocf_pkg::KEY_W-1:0];
  endfunction

  function automatic logic [mocf_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return rand_mac();
  endfunction

  task automatic run_directed();
    logic [mocf_pkg::KEY_W-1:0] ones;
    logic [mocf_pkg::KEY_W-1:0] k1;
    ones = '1;
    k1   = rand_mac();
    send_op(mocf_pkg::KIND_LOOKUP, '0, 16'h0000);      // empty table
    send_op(mocf_pkg::KIND_INSERT, '0, 16'h0000);
    send_op(mocf_pkg::KIND_INSERT, ones, 16'hFFFF);
    send_op(mocf_pkg::KIND_LOOKUP, '0, 16'hFFFF);
    send_op(mocf_pkg::KIND_LOOKUP, ones, 16'h0000);
    send_op(mocf_pkg::KIND_INSERT, ones, 16'h1234);    // update in place
    send_op(mocf_pkg::KIND_LOOKUP, ones, 16'h0000);
    send_op(KIND_RESERVED, ones, 16'hFFFF);            // no effect
    send_op(mocf_pkg::KIND_LOOKUP, ones, 16'h0000);
    send_op(mocf_pkg::KIND_INSERT, k1, 16'hA5A5);
    send_op(mocf_pkg::KIND_LOOKUP, k1 ^ 48'h1, 16'h0000);
    send_op(mocf_pkg::KIND_LOOKUP, k1, 16'h0000);
    send_op(mocf_pkg::KIND_CLEAR, ones, 16'hFFFF);
    send_op(mocf_pkg::KIND_LOOKUP, ones, 16'h0000);    // stale entry must miss
    send_op(mocf_pkg::KIND_INSERT, 48'h5555_5555_5555, 16'h5555);
    send_op(mocf_pkg::KIND_LOOKUP, 48'h5555_5555_5555, 16'h0000);
    send_op(mocf_pkg::KIND_LOOKUP, '0, 16'h0000);
    send_op(mocf_pkg::KIND_LOOKUP, k1, 16'h0000);
    send_op(mocf_pkg::KIND_INSERT, 48'hAAAA_AAAA_AAAA, 16'hAAAA);
    send_op(mocf_pkg::KIND_INSERT, 48'hAAAA_AAAA_AAAA, 16'h0001);
    send_op(mocf_pkg::KIND_LOOKUP, 48'hAAAA_AAAA_AAAA, 16'hFFFF);
    send_op(mocf_pkg::KIND_CLEAR, '0, 16'h0000);
  endtask

  task automatic run_segment(input int seg);
    int i;
    int r;
    logic [mocf_pkg::KIND_W-1:0] kind;
    for (i = 0; i < POOL_SIZE; i++) key_pool[i] = rand_mac();
    key_pool[0] = '0;
    key_pool[1] = '1;
    tx_calm = (seg % 3 == 1);
    rx_calm = (seg % 3 == 2);
    // fill past capacity so FIFO replacement starts evicting
    for (i = 0; i < FILL_ITEMS; i++)
      send_op(mocf_pkg::KIND_INSERT, key_pool[i], 16'($urandom));
    for (i = 0; i < SEG_ITEMS - FILL_ITEMS; i++) begin
      r = $urandom_range(0, 199);
      if (r < 95)       kind = mocf_pkg::KIND_LOOKUP;
      else if (r < 193) kind = mocf_pkg::KIND_INSERT;
      else if (r < 196) kind = mocf_pkg::KIND_CLEAR;
      else              kind = KIND_RESERVED;
      send_op(kind, pick_key(), 16'($urandom));
    end
  endtask

  initial begin
    int seg;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    drain_results();
    for (seg = 0; seg < SEGMENTS; seg++) begin
      run_segment(seg);
      drain_results();
    end
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Sent %0d transactions (%0d clears): %0d hits, %0d FIFO evictions checked,",
             n_sent, n_clear, hit_count, evict_count);
    $display("with random 0-6 cycle source gaps and sink stalls plus stall-free stretches.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
